@@ src/wcr_pkg.sv @@
package wcr_pkg;

	// Fixed field widths
	localparam int COORD_W  = 32;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int ABS_W    = COORD_W;
	localparam int SQ_W     = 2 * ABS_W;
	localparam int SUM_W    = SQ_W + 2;
	localparam int INV_W    = 32;
	localparam int WEIGHT_W = 17;

	// Fixed point format of coordinates and reciprocal radius
	localparam int FRAC_BITS = 16;

	// Square root: one result bit per stage
	localparam int SQRT_STAGES = (SUM_W + 1) / 2;
	localparam int RAD_W       = 2 * SQRT_STAGES;
	localparam int ROOT_W      = SQRT_STAGES;
	localparam int REM_W       = ROOT_W + 2;

	// Scaled distance
	localparam int PROD_W = ROOT_W + INV_W;
	localparam int R_SH   = 2 * FRAC_BITS - 16;
	localparam logic [PROD_W-1:0] ONE2F   = PROD_W'(1) << (2 * FRAC_BITS);
	localparam logic [PROD_W:0]   R_ROUND = ((PROD_W + 1)'(1) << R_SH) >> 1;

	// Q1.16 constants
	localparam logic [WEIGHT_W-1:0] ONE16 = 17'h10000;
	localparam int HALF16 = 32768;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X   = 2'd0,
		CFG_CENTER_Y   = 2'd1,
		CFG_CENTER_Z   = 2'd2,
		CFG_INV_RADIUS = 2'd3
	} cfg_index_t;

	// Square root unit payloads
	typedef struct packed {
		logic [SUM_W-1:0] rad;
		logic             last;
	} sqrt_req_t;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic              last;
	} sqrt_rsp_t;

endpackage

@@ src/wcr_pt_if.sv @@
interface wcr_pt_if;
	import wcr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic                      last_point;

	modport source (output valid, pos_x, pos_y, pos_z, last_point, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, last_point, output ready);
endinterface

@@ src/wcr_wt_if.sv @@
interface wcr_wt_if;
	import wcr_pkg::*;

	logic                valid;
	logic                ready;
	logic [WEIGHT_W-1:0] weight;
	logic                last_weight;

	modport source (output valid, weight, last_weight, input ready);
	modport sink   (input valid, weight, last_weight, output ready);
endinterface

@@ src/wcr_isqrt.sv @@
module wcr_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wcr_pkg::sqrt_req_t in_req,
	output logic               out_valid,
	input  logic               out_ready,
	output wcr_pkg::sqrt_rsp_t out_rsp
);
	import wcr_pkg::*;

	// Per-stage state of the digit recurrence
	logic [REM_W-1:0]  rem_s  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [SQRT_STAGES];
	logic [RAD_W-1:0]  rad_s  [SQRT_STAGES];
	logic              last_s [SQRT_STAGES];
	logic              vld_s  [SQRT_STAGES];
	logic              en;

	// Whole pipe advances together unless the last beat is held
	assign en       = !vld_s[SQRT_STAGES-1] || out_ready;
	assign in_ready = en;

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;
		logic              last_in;
		logic              vld_in;
		logic [REM_W+1:0]  cur;
		logic [REM_W+1:0]  trial;
		logic [REM_W+1:0]  diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = RAD_W'(in_req.rad);
			assign last_in = in_req.last;
			assign vld_in  = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign last_in = last_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		// Bring down the next two radicand bits and try root*4+1
		assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
		assign trial = {{(REM_W - ROOT_W){1'b0}}, root_in, 2'b01};
		assign diff  = cur - trial;
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
				rad_s[k]  <= {rad_in[RAD_W-3:0], 2'b00};
				last_s[k] <= last_in;
			end
		end
	end

	assign out_valid    = vld_s[SQRT_STAGES-1];
	assign out_rsp.root = root_s[SQRT_STAGES-1];
	assign out_rsp.last = last_s[SQRT_STAGES-1];

endmodule

@@ src/wendland_c2_rbf_weight_unit.sv @@
// Wendland C2 weight pipeline: one point beat in, one weight beat out.
// Pipeline: 4 offset/square stages, 33 square root stages at one root bit each,
// then 6 scale/polynomial stages.
// Throughput: one point per cycle while the weight output is not held back; the square root stages stall together.
// Reset clears all valid bits and loads the control point with 0 and the
// reciprocal radius with 1.0. There is no clearing pass.
module wendland_c2_rbf_weight_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	wcr_pt_if.sink                       points,
	wcr_wt_if.source                     weights,
	input  logic                         cfg_we,
	input  logic [wcr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wcr_pkg::INV_W-1:0]    cfg_data
);
	import wcr_pkg::*;

	// Configuration registers
	logic [COORD_W-1:0] center_q [3];
	logic [INV_W-1:0]   inv_radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0]  <= '0;
			center_q[1]  <= '0;
			center_q[2]  <= '0;
			inv_radius_q <= INV_W'(32'h0001_0000);
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CENTER_X:   center_q[0]  <= cfg_data;
				CFG_CENTER_Y:   center_q[1]  <= cfg_data;
				CFG_CENTER_Z:   center_q[2]  <= cfg_data;
				CFG_INV_RADIUS: inv_radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage enables: a stage loads when empty or when the next one moves
	logic en_s1, en_s2, en_s3, en_s4;
	logic en_s5, en_s6, en_s7, en_s8, en_s9, en_s10;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic sq_in_ready, sq_out_valid;
	sqrt_req_t sq_req;
	sqrt_rsp_t sq_rsp;

	assign en_s10 = !vld_s10 || weights.ready;
	assign en_s9  = !vld_s9 || en_s10;
	assign en_s8  = !vld_s8 || en_s9;
	assign en_s7  = !vld_s7 || en_s8;
	assign en_s6  = !vld_s6 || en_s7;
	assign en_s5  = !vld_s5 || en_s6;
	assign en_s4  = !vld_s4 || sq_in_ready;
	assign en_s3  = !vld_s3 || en_s4;
	assign en_s2  = !vld_s2 || en_s3;
	assign en_s1  = !vld_s1 || en_s2;

	assign points.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			if (en_s1)  vld_s1  <= points.valid;
			if (en_s2)  vld_s2  <= vld_s1;
			if (en_s3)  vld_s3  <= vld_s2;
			if (en_s4)  vld_s4  <= vld_s3;
			if (en_s5)  vld_s5  <= sq_out_valid;
			if (en_s6)  vld_s6  <= vld_s5;
			if (en_s7)  vld_s7  <= vld_s6;
			if (en_s8)  vld_s8  <= vld_s7;
			if (en_s9)  vld_s9  <= vld_s8;
			if (en_s10) vld_s10 <= vld_s9;
		end
	end

	// Offset, magnitude and square per axis
	logic [COORD_W-1:0] pos [3];
	logic [DIFF_W-1:0]  dif_s1 [3];
	logic [ABS_W-1:0]   abs_s2 [3];
	logic [SQ_W-1:0]    sq_s3  [3];
	logic [SUM_W-1:0]   sum_s4;
	logic               last_s1, last_s2, last_s3, last_s4;

	assign pos[0] = points.pos_x;
	assign pos[1] = points.pos_y;
	assign pos[2] = points.pos_z;

	for (genvar i = 0; i < 3; i++) begin : g_axis
		logic [DIFF_W-1:0] neg;

		assign neg = DIFF_W'(0) - dif_s1[i];

		always_ff @(posedge clk) begin
			if (en_s1) begin
				dif_s1[i] <= {pos[i][COORD_W-1], pos[i]} - {center_q[i][COORD_W-1], center_q[i]};
			end
			if (en_s2) begin
				abs_s2[i] <= dif_s1[i][DIFF_W-1] ? neg[ABS_W-1:0] : dif_s1[i][ABS_W-1:0];
			end
			if (en_s3) begin
				sq_s3[i] <= SQ_W'(abs_s2[i]) * SQ_W'(abs_s2[i]);
			end
		end
	end

	// Sum of squares
	always_ff @(posedge clk) begin
		if (en_s1) last_s1 <= points.last_point;
		if (en_s2) last_s2 <= last_s1;
		if (en_s3) last_s3 <= last_s2;
		if (en_s4) begin
			sum_s4  <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
			last_s4 <= last_s3;
		end
	end

	assign sq_req.rad  = sum_s4;
	assign sq_req.last = last_s4;

	wcr_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_ready  (sq_in_ready),
		.in_req    (sq_req),
		.out_valid (sq_out_valid),
		.out_ready (en_s5),
		.out_rsp   (sq_rsp)
	);

	// Scale distance by the reciprocal radius
	logic [PROD_W-1:0] prod_s5;
	logic              last_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			prod_s5 <= PROD_W'(sq_rsp.root) * PROD_W'(inv_radius_q);
			last_s5 <= sq_rsp.last;
		end
	end

	// Round r to Q0.16; r at or above one forces a zero weight
	logic [PROD_W:0]     r_sum;
	logic [PROD_W:0]     r_shift;
	logic [WEIGHT_W-1:0] r17;
	logic [WEIGHT_W-1:0] u_s6;
	logic [18:0]         p4_s6, p4_s7, p4_s8;
	logic                zero_s6, zero_s7, zero_s8, zero_s9;
	logic                last_s6, last_s7, last_s8, last_s9, last_s10;

	assign r_sum   = {1'b0, prod_s5} + R_ROUND;
	assign r_shift = r_sum >> R_SH;
	assign r17     = r_shift[WEIGHT_W-1:0];

	always_ff @(posedge clk) begin
		if (en_s6) begin
			zero_s6 <= (prod_s5 >= ONE2F) || r17[WEIGHT_W-1];
			u_s6    <= ONE16 - {1'b0, r17[15:0]};
			p4_s6   <= 19'(ONE16) + {1'b0, r17[15:0], 2'b00};
			last_s6 <= last_s5;
		end
	end

	// (1-r)^2
	logic [33:0] usq_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			usq_s7  <= 34'(u_s6) * 34'(u_s6);
			p4_s7   <= p4_s6;
			zero_s7 <= zero_s6;
			last_s7 <= last_s6;
		end
	end

	// (1-r)^4
	logic [34:0]         u2_sum;
	logic [WEIGHT_W-1:0] u2;
	logic [33:0]         u2sq_s8;

	assign u2_sum = {1'b0, usq_s7} + 35'(HALF16);
	assign u2     = u2_sum[32:16];

	always_ff @(posedge clk) begin
		if (en_s8) begin
			u2sq_s8 <= 34'(u2) * 34'(u2);
			p4_s8   <= p4_s7;
			zero_s8 <= zero_s7;
			last_s8 <= last_s7;
		end
	end

	// times (1+4r)
	logic [34:0]         u4_sum;
	logic [WEIGHT_W-1:0] u4;
	logic [35:0]         wp_s9;

	assign u4_sum = {1'b0, u2sq_s8} + 35'(HALF16);
	assign u4     = u4_sum[32:16];

	always_ff @(posedge clk) begin
		if (en_s9) begin
			wp_s9   <= 36'(u4) * 36'(p4_s8);
			zero_s9 <= zero_s8;
			last_s9 <= last_s8;
		end
	end

	// Final rounding, zero forcing and saturation at 1.0
	logic [36:0]         w_sum;
	logic [20:0]         w_full;
	logic [WEIGHT_W-1:0] weight_s10;

	assign w_sum  = {1'b0, wp_s9} + 37'(HALF16);
	assign w_full = w_sum[36:16];

	always_ff @(posedge clk) begin
		if (en_s10) begin
			if (zero_s9) begin
				weight_s10 <= '0;
			end else if (w_full > 21'(ONE16)) begin
				weight_s10 <= ONE16;
			end else begin
				weight_s10 <= w_full[WEIGHT_W-1:0];
			end
			last_s10 <= last_s9;
		end
	end

	assign weights.valid       = vld_s10;
	assign weights.weight      = weight_s10;
	assign weights.last_weight = last_s10;

endmodule
